// ===== sv/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// Color map lookup package
// Shared codes, field widths and default sizes for the interpolating color
// lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package clm_pkg;

    localparam int MAX_ENTRIES_DEFAULT  = 256;
    localparam int CHANNEL_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH          = 2;

    localparam int KIND_W        = 2;
    localparam int INDEX_W       = 8;
    localparam int COLOR_W       = 16;
    localparam int VALUE_W       = 18;
    localparam int ENTRY_COUNT_W = 9;
    localparam int FRAC_W        = 16;
    localparam int NUM_CHANNELS  = 3;

    localparam logic [FRAC_W:0]   ONE_Q16  = 17'h10000;
    localparam logic [FRAC_W-1:0] HALF_Q16 = 16'h8000;

    typedef enum logic [KIND_W-1:0] {
        KIND_MAP    = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_SET    = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_MAP   = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

endpackage

`default_nettype wire

// ===== sv/clm_req_if.sv =====
// ----------------------------------------------------------------------------
// Color map request channel
// Valid/ready channel that carries one table or map request.
// ----------------------------------------------------------------------------
`default_nettype none

interface clm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic signed [17:0] value;

    modport source (
        output valid, kind, index, red_in, green_in, blue_in, value,
        input  ready
    );

    modport sink (
        input  valid, kind, index, red_in, green_in, blue_in, value,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/clm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Color map response channel
// Valid/ready channel that carries one color, the entry count and the error.
// ----------------------------------------------------------------------------
`default_nettype none

interface clm_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [8:0]  entry_count;
    logic        error;

    modport source (
        output valid, red_out, green_out, blue_out, entry_count, error,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, entry_count, error,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/clm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data held when not read.
// ----------------------------------------------------------------------------
`default_nettype none

module clm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire  logic                             clk,
    input  wire  logic                             we,
    input  wire  logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire  logic [WIDTH-1:0]                 wdata,
    input  wire  logic                             re,
    input  wire  logic [$clog2(DEPTH)-1:0]         raddr_a,
    input  wire  logic [$clog2(DEPTH)-1:0]         raddr_b,
    output logic [WIDTH-1:0]                       rdata_a,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// ===== sv/clm_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module clm_fifo
    import clm_pkg::*;
#(
    parameter type item_t = logic,
    parameter int  DEPTH  = QUEUE_DEPTH
) (
    input  wire  logic  clk,
    input  wire  logic  rst_n,
    input  wire  logic  push,
    input  wire  item_t push_data,
    output logic        full,
    input  wire  logic  pop,
    output item_t       pop_data,
    output logic        empty
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    item_t              storage_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            storage_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = storage_reg[rd_ptr_reg];
    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign empty    = (fill_reg == '0);

endmodule

`default_nettype wire

// ===== sv/clm_front.sv =====
// ----------------------------------------------------------------------------
// Color map front end
// Accepts requests, checks them against the entry count, keeps the count and
// turns each request into a table command, with bin and fraction for a map.
// ----------------------------------------------------------------------------
`default_nettype none

module clm_front
    import clm_pkg::*;
#(
    parameter type cmd_t        = logic,
    parameter int  MAX_ENTRIES  = MAX_ENTRIES_DEFAULT,
    parameter int  CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
    input  wire  logic clk,
    input  wire  logic rst_n,
    clm_req_if.sink    req,
    input  wire  logic full,
    output logic       push,
    output cmd_t       cmd
);

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW  = (CNTW > INDEX_W) ? CNTW : INDEX_W;
    localparam int SCW   = FRAC_W + 1 + CNTW;

    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;
    logic [CNTW-1:0]  cnt_m1;
    logic [CNTW-1:0]  cnt_m2;
    logic [FRAC_W:0]  v_clamp;
    logic [SCW-1:0]   scaled;
    logic [AW-1:0]    map_bin;
    logic [FRAC_W:0]  map_frac;
    logic             index_ok;
    logic             accept;

    assign req.ready = !full;
    assign accept    = req.valid && !full;
    assign push      = accept;

    assign cnt_m1   = count_reg - CNTW'(1);
    assign cnt_m2   = count_reg - CNTW'(2);
    assign index_ok = CMPW'(req.index) < CMPW'(count_reg);

    always_comb
    begin
        if (req.value[VALUE_W-1])
        begin
            v_clamp = '0;
        end
        else if (req.value[FRAC_W] && (|req.value[FRAC_W-1:0]))
        begin
            v_clamp = ONE_Q16;
        end
        else
        begin
            v_clamp = req.value[FRAC_W:0];
        end
    end

    assign scaled = SCW'(v_clamp) * SCW'(cnt_m1);

    always_comb
    begin
        if (v_clamp[FRAC_W])
        begin
            map_bin  = AW'(cnt_m2);
            map_frac = ONE_Q16;
        end
        else
        begin
            map_bin  = AW'(scaled >> FRAC_W);
            map_frac = {1'b0, scaled[FRAC_W-1:0]};
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_NONE;
        count_next = count_reg;
        cmd.wdata  = {CHANNEL_BITS'(req.red_in), CHANNEL_BITS'(req.green_in),
                      CHANNEL_BITS'(req.blue_in)};
        case (kind_t'(req.kind))
            KIND_MAP:
            begin
                if (count_reg < CNTW'(2))
                begin
                    cmd.err = 1'b1;
                end
                else
                begin
                    cmd.op     = OP_MAP;
                    cmd.addr_a = map_bin;
                    cmd.addr_b = map_bin + AW'(1);
                    cmd.frac   = map_frac;
                end
            end
            KIND_APPEND:
            begin
                if (count_reg == CNTW'(MAX_ENTRIES))
                begin
                    cmd.err = 1'b1;
                end
                else
                begin
                    cmd.op     = OP_WRITE;
                    cmd.addr_a = AW'(count_reg);
                    count_next = count_reg + CNTW'(1);
                end
            end
            KIND_SET:
            begin
                if (!index_ok)
                begin
                    cmd.err = 1'b1;
                end
                else
                begin
                    cmd.op     = OP_WRITE;
                    cmd.addr_a = AW'(req.index);
                end
            end
            KIND_READ:
            begin
                if (!index_ok)
                begin
                    cmd.err = 1'b1;
                end
                else
                begin
                    cmd.op     = OP_READ;
                    cmd.addr_a = AW'(req.index);
                end
            end
            default:
            begin
                cmd.err = 1'b1;
            end
        endcase
        cmd.count = ENTRY_COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/clm_back.sv =====
// ----------------------------------------------------------------------------
// Color map back end
// Issues table writes and reads in order, blends the two neighboring entries
// per channel and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clm_back
    import clm_pkg::*;
#(
    parameter type cmd_t        = logic,
    parameter int  MAX_ENTRIES  = MAX_ENTRIES_DEFAULT,
    parameter int  CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic empty,
    input  wire  cmd_t cmd,
    output logic       pop,
    clm_rsp_if.source  rsp
);

    localparam int CW = CHANNEL_BITS;
    localparam int TW = NUM_CHANNELS * CW;
    localparam int PW = CW + FRAC_W + 1;
    localparam int SW = PW + 1;

    logic             s2_valid_reg;
    logic             s2_valid_next;
    cmd_t             s2_cmd_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;
    logic [COLOR_W-1:0] blue_reg;
    logic [ENTRY_COUNT_W-1:0] count_reg;
    logic             err_reg;

    logic             out_free;
    logic             s2_advance;
    logic             issue;
    logic             out_load;
    logic             ram_we;
    logic             ram_re;
    logic [TW-1:0]    rdata_a;
    logic [TW-1:0]    rdata_b;
    logic [TW-1:0]    blend;
    logic [TW-1:0]    result;
    logic [FRAC_W:0]  frac_inv;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign s2_advance = !s2_valid_reg || out_free;
    assign issue      = !empty && s2_advance;
    assign pop        = issue;
    assign out_load   = s2_valid_reg && out_free;

    assign ram_we = issue && (cmd.op == OP_WRITE);
    assign ram_re = issue && ((cmd.op == OP_MAP) || (cmd.op == OP_READ));

    clm_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (cmd.addr_a),
        .wdata   (cmd.wdata),
        .re      (ram_re),
        .raddr_a (cmd.addr_a),
        .raddr_b (cmd.addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign frac_inv = ONE_Q16 - s2_cmd_reg.frac;

    for (genvar k = 0; k < NUM_CHANNELS; k++)
    begin : g_blend
        logic [PW-1:0] prod_a;
        logic [PW-1:0] prod_b;
        logic [SW-1:0] sum;

        assign prod_a = PW'(rdata_a[k*CW +: CW]) * PW'(frac_inv);
        assign prod_b = PW'(rdata_b[k*CW +: CW]) * PW'(s2_cmd_reg.frac);
        assign sum    = SW'(prod_a) + SW'(prod_b) + SW'(HALF_Q16);
        assign blend[k*CW +: CW] = sum[FRAC_W +: CW];
    end

    always_comb
    begin
        case (s2_cmd_reg.op)
            OP_MAP:   result = blend;
            OP_READ:  result = rdata_a;
            OP_WRITE: result = '0;
            OP_NONE:  result = '0;
            default:  result = '0;
        endcase
    end

    always_comb
    begin
        s2_valid_next = s2_advance ? issue : s2_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_cmd_reg <= cmd;
        end
        if (out_load)
        begin
            red_reg   <= COLOR_W'(result[2*CW +: CW]);
            green_reg <= COLOR_W'(result[CW +: CW]);
            blue_reg  <= COLOR_W'(result[0 +: CW]);
            count_reg <= s2_cmd_reg.count;
            err_reg   <= s2_cmd_reg.err;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.red_out     = red_reg;
    assign rsp.green_out   = green_reg;
    assign rsp.blue_out    = blue_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.error       = err_reg;

endmodule

`default_nettype wire

// ===== sv/colormap_lerp_lookup_unit.sv =====
// Path: command queue, then table RAM read into stage 2, then output register.
// Throughput: one request per cycle unless stalled, set by the table RAM
// (one write or one dual-address read per cycle) and the single blend stage.
// Reset: entry count cleared, queue and pipeline emptied; table contents are
// undefined until written and are never cleared.
// ----------------------------------------------------------------------------
// Colormap interpolating lookup unit
// Table of RGB entries with append, set, read and linearly blended map.
// ----------------------------------------------------------------------------
`default_nettype none

module colormap_lerp_lookup_unit
    import clm_pkg::*;
#(
    parameter int MAX_ENTRIES  = MAX_ENTRIES_DEFAULT,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    clm_req_if.sink    req,
    clm_rsp_if.source  rsp
);

    localparam int AW = $clog2(MAX_ENTRIES);

    typedef struct packed {
        op_t                             op;
        logic [AW-1:0]                   addr_a;
        logic [AW-1:0]                   addr_b;
        logic [FRAC_W:0]                 frac;
        logic [NUM_CHANNELS*CHANNEL_BITS-1:0] wdata;
        logic [ENTRY_COUNT_W-1:0]        count;
        logic                            err;
    } cmd_t;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    clm_front #(
        .cmd_t        (cmd_t),
        .MAX_ENTRIES  (MAX_ENTRIES),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .full  (full),
        .push  (push),
        .cmd   (front_cmd)
    );

    clm_fifo #(
        .item_t (cmd_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (back_cmd),
        .empty     (empty)
    );

    clm_back #(
        .cmd_t        (cmd_t),
        .MAX_ENTRIES  (MAX_ENTRIES),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .cmd   (back_cmd),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_colormap_lerp_lookup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colormap interpolating lookup unit testbench
// A directed table covers the empty, single-entry and two-entry tables, value
// clamping, bad indexes and entry overwrites. A random phase follows that
// fills the table to its limit and then mixes map, append, set and read
// requests. Typed rows are checked against their own expected response, all
// others against a behavioral color predictor. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_colormap_lerp_lookup_unit;
    import clm_pkg::*;

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEFAULT;
    localparam int NUM_RANDOM  = 800;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        kind_t                      kind;
        logic [INDEX_W-1:0]         index;
        logic [COLOR_W-1:0]         red;
        logic [COLOR_W-1:0]         green;
        logic [COLOR_W-1:0]         blue;
        logic signed [VALUE_W-1:0]  value;
    } color_req_t;

    typedef struct packed {
        logic [COLOR_W-1:0]         red;
        logic [COLOR_W-1:0]         green;
        logic [COLOR_W-1:0]         blue;
        logic [ENTRY_COUNT_W-1:0]   count;
        logic                       error;
    } color_rsp_t;

    typedef struct packed {
        color_req_t rq;
        logic       typed;
        color_rsp_t rs;
    } lookup_row_t;

    logic clk;
    logic rst_n;

    clm_req_if req_ch ();
    clm_rsp_if rsp_ch ();

    colormap_lerp_lookup_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [COLOR_W-1:0] lut_red   [0:TABLE_DEPTH-1];
    logic [COLOR_W-1:0] lut_green [0:TABLE_DEPTH-1];
    logic [COLOR_W-1:0] lut_blue  [0:TABLE_DEPTH-1];
    int                 lut_count;

    color_rsp_t  pending_colors [$];
    lookup_row_t lookup_rows [$];
    int          mismatch_cnt;
    bit          tx_quiet;
    bit          rx_quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_colormap_lerp_lookup_unit NOT OK");
        $finish;
    end

    function automatic logic [COLOR_W-1:0] mix_channel(input logic [COLOR_W-1:0] a,
                                                       input logic [COLOR_W-1:0] b,
                                                       input longint unsigned frac);
        longint unsigned acc;
        acc = 64'(a) * (64'd65536 - frac) + 64'(b) * frac + 64'd32768;
        return acc[31:16];
    endfunction

    function automatic color_rsp_t predict_lookup(input color_req_t rq);
        color_rsp_t      rs;
        longint          vq;
        longint unsigned scaled;
        longint unsigned frac;
        int              bin;
        rs = '0;
        case (rq.kind)
            KIND_MAP:
            begin
                if (lut_count < 2)
                    rs.error = 1'b1;
                else
                begin
                    vq = $signed(rq.value);
                    if (vq < 0)
                        vq = 0;
                    if (vq > 65536)
                        vq = 65536;
                    scaled = 64'(vq) * 64'(lut_count - 1);
                    bin    = int'(scaled >> 16);
                    frac   = scaled & 64'hFFFF;
                    if (bin > lut_count - 2)
                    begin
                        bin  = lut_count - 2;
                        frac = 64'd65536;
                    end
                    rs.red   = mix_channel(lut_red[bin], lut_red[bin + 1], frac);
                    rs.green = mix_channel(lut_green[bin], lut_green[bin + 1], frac);
                    rs.blue  = mix_channel(lut_blue[bin], lut_blue[bin + 1], frac);
                end
            end
            KIND_APPEND:
            begin
                if (lut_count >= TABLE_DEPTH)
                    rs.error = 1'b1;
                else
                begin
                    lut_red[lut_count]   = rq.red;
                    lut_green[lut_count] = rq.green;
                    lut_blue[lut_count]  = rq.blue;
                    lut_count++;
                end
            end
            default:
            begin
                if (int'(rq.index) >= lut_count)
                    rs.error = 1'b1;
                else if (rq.kind == KIND_SET)
                begin
                    lut_red[rq.index]   = rq.red;
                    lut_green[rq.index] = rq.green;
                    lut_blue[rq.index]  = rq.blue;
                end
                else
                begin
                    rs.red   = lut_red[rq.index];
                    rs.green = lut_green[rq.index];
                    rs.blue  = lut_blue[rq.index];
                end
            end
        endcase
        rs.count = lut_count[ENTRY_COUNT_W-1:0];
        return rs;
    endfunction

    function automatic lookup_row_t make_row(input kind_t kind, input int idx,
                                             input int r, input int g, input int b,
                                             input int v, input bit typed,
                                             input int er, input int eg, input int eb,
                                             input int ecnt, input bit eerr);
        lookup_row_t row;
        row.rq.kind     = kind;
        row.rq.index    = idx[INDEX_W-1:0];
        row.rq.red      = r[COLOR_W-1:0];
        row.rq.green    = g[COLOR_W-1:0];
        row.rq.blue     = b[COLOR_W-1:0];
        row.rq.value    = v[VALUE_W-1:0];
        row.typed       = typed;
        row.rs.red      = er[COLOR_W-1:0];
        row.rs.green    = eg[COLOR_W-1:0];
        row.rs.blue     = eb[COLOR_W-1:0];
        row.rs.count    = ecnt[ENTRY_COUNT_W-1:0];
        row.rs.error    = eerr;
        return row;
    endfunction

    task automatic send_request(input color_req_t rq, input bit typed, input color_rsp_t want);
        int         gap;
        color_rsp_t predicted;
        if ($urandom_range(0, 63) == 0)
            tx_quiet = ~tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= rq.kind;
        req_ch.index    <= rq.index;
        req_ch.red_in   <= rq.red;
        req_ch.green_in <= rq.green;
        req_ch.blue_in  <= rq.blue;
        req_ch.value    <= rq.value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_lookup(rq);
        pending_colors.push_back(typed ? want : predicted);
    endtask

    initial
    begin
        color_rsp_t got;
        color_rsp_t want;
        int         stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                rx_quiet = ~rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            got.red   = rsp_ch.red_out;
            got.green = rsp_ch.green_out;
            got.blue  = rsp_ch.blue_out;
            got.count = rsp_ch.entry_count;
            got.error = rsp_ch.error;
            if (pending_colors.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected response: rgb %h %h %h count %0d error %b",
                             got.red, got.green, got.blue, got.count, got.error);
            end
            else
            begin
                want = pending_colors.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.count !== want.count ||
                    got.error !== want.error)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"mismatch: exp rgb %h %h %h count %0d error %b, ",
                                  "got rgb %h %h %h count %0d error %b"},
                                 want.red, want.green, want.blue, want.count, want.error,
                                 got.red, got.green, got.blue, got.count, got.error);
                end
            end
        end
    end

    initial
    begin
        color_req_t rq;
        int         pick;
        int         mode;
        bit         filling;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.kind     <= KIND_MAP;
        req_ch.index    <= '0;
        req_ch.red_in   <= '0;
        req_ch.green_in <= '0;
        req_ch.blue_in  <= '0;
        req_ch.value    <= '0;
        mismatch_cnt = 0;
        lut_count    = 0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            lut_red[i]   = '0;
            lut_green[i] = '0;
            lut_blue[i]  = '0;
        end

        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1));
        lookup_rows.push_back(make_row(KIND_READ,   0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1));
        lookup_rows.push_back(make_row(KIND_SET,    0, 'hFFFF, 'hFFFF, 'hFFFF, 0, 1,
                                       0, 0, 0, 0, 1));
        lookup_rows.push_back(make_row(KIND_APPEND, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 32768, 1, 0, 0, 0, 1, 1));
        lookup_rows.push_back(make_row(KIND_READ,   0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        lookup_rows.push_back(make_row(KIND_APPEND, 0, 'hFFFF, 'hFFFF, 'hFFFF, 0, 1,
                                       0, 0, 0, 2, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 0, 1, 0, 0, 0, 2, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 65536, 1,
                                       'hFFFF, 'hFFFF, 'hFFFF, 2, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, -131072, 1, 0, 0, 0, 2, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 131071, 1,
                                       'hFFFF, 'hFFFF, 'hFFFF, 2, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 32768, 1,
                                       'h8000, 'h8000, 'h8000, 2, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, -1, 1, 0, 0, 0, 2, 0));
        lookup_rows.push_back(make_row(KIND_READ,   1, 0, 0, 0, 0, 1,
                                       'hFFFF, 'hFFFF, 'hFFFF, 2, 0));
        lookup_rows.push_back(make_row(KIND_READ,   2, 0, 0, 0, 0, 1, 0, 0, 0, 2, 1));
        lookup_rows.push_back(make_row(KIND_SET,  255, 1, 2, 3, 0, 1, 0, 0, 0, 2, 1));
        lookup_rows.push_back(make_row(KIND_SET,    0, 'h1234, 'h5678, 'h9ABC, 0, 1,
                                       0, 0, 0, 2, 0));
        lookup_rows.push_back(make_row(KIND_READ,   0, 0, 0, 0, 0, 1,
                                       'h1234, 'h5678, 'h9ABC, 2, 0));
        lookup_rows.push_back(make_row(KIND_APPEND, 0, 'h8000, 'h0001, 'hFFFE, 0, 1,
                                       0, 0, 0, 3, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 32768, 0, 0, 0, 0, 0, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 65535, 0, 0, 0, 0, 0, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 98304, 1,
                                       'h8000, 'h0001, 'hFFFE, 3, 0));
        lookup_rows.push_back(make_row(KIND_SET,    2, 'h5555, 'hAAAA, 'h0F0F, 0, 1,
                                       0, 0, 0, 3, 0));
        lookup_rows.push_back(make_row(KIND_MAP,    0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        lookup_rows.push_back(make_row(KIND_READ,   2, 0, 0, 0, 0, 1,
                                       'h5555, 'hAAAA, 'h0F0F, 3, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (lookup_rows[i])
            send_request(lookup_rows[i].rq, lookup_rows[i].typed, lookup_rows[i].rs);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM / 2)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending_colors.size() != 0)
                    @(posedge clk);
            end
            filling = (i < NUM_RANDOM / 2);
            pick    = $urandom_range(0, 99);
            if (filling)
                rq.kind = (pick < 70) ? KIND_APPEND : (pick < 85) ? KIND_MAP :
                          (pick < 93) ? KIND_SET : KIND_READ;
            else
                rq.kind = (pick < 8) ? KIND_APPEND : (pick < 58) ? KIND_MAP :
                          (pick < 75) ? KIND_SET : KIND_READ;
            if (lut_count > 0 && $urandom_range(0, 4) != 0)
                rq.index = INDEX_W'($urandom_range(0, lut_count - 1));
            else
                rq.index = INDEX_W'($urandom_range(0, 255));
            mode = $urandom_range(0, 9);
            rq.red   = (mode == 0) ? 16'h0000 : (mode == 1) ? 16'hFFFF :
                       COLOR_W'($urandom_range(0, 65535));
            rq.green = (mode == 0) ? 16'hFFFF : (mode == 1) ? 16'h0000 :
                       COLOR_W'($urandom_range(0, 65535));
            rq.blue  = (mode == 2) ? 16'h0000 : (mode == 3) ? 16'hFFFF :
                       COLOR_W'($urandom_range(0, 65535));
            case ($urandom_range(0, 7))
                0, 1:    rq.value = VALUE_W'($urandom_range(0, 262143));
                2:
                begin
                    case ($urandom_range(0, 5))
                        0:       rq.value = 18'sd0;
                        1:       rq.value = 18'sd65536;
                        2:       rq.value = 18'sd65535;
                        3:       rq.value = 18'sd1;
                        4:       rq.value = -18'sd131072;
                        default: rq.value = 18'sd131071;
                    endcase
                end
                default: rq.value = VALUE_W'($urandom_range(0, 65536));
            endcase
            send_request(rq, 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0 && pending_colors.size() == 0)
            $display("tb_colormap_lerp_lookup_unit OK");
        else
            $display("tb_colormap_lerp_lookup_unit NOT OK");
        $finish;
    end

endmodule
